// ----- src/bmtf_pkg.sv -----
package bmtf_pkg;

  // field widths
  localparam int BTN_W  = 12;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 4;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP   = 2'd2;

  // register reset values
  localparam logic [BYTE_W-1:0] START_RST = 8'd18;
  localparam logic [BYTE_W-1:0] END_RST   = 8'd19;
  localparam logic [BYTE_W-1:0] SEP_RST   = 8'd44;

  // frame code registers as seen by the sequencer
  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] end_code;
    logic [BYTE_W-1:0] separator_code;
  } cfg_t;

  // queue status toward front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LETTER,
    SEQ_SEP,
    SEQ_END
  } seq_state_t;

  // letter for mask bit k, table VBNM34567890 read from the end
  function automatic logic [BYTE_W-1:0] letter_of(input logic [IDX_W-1:0] k);
    logic [BYTE_W-1:0] c;
    case (k)
      4'd0:    c = 8'h30; // '0'
      4'd1:    c = 8'h39; // '9'
      4'd2:    c = 8'h38; // '8'
      4'd3:    c = 8'h37; // '7'
      4'd4:    c = 8'h36; // '6'
      4'd5:    c = 8'h35; // '5'
      4'd6:    c = 8'h34; // '4'
      4'd7:    c = 8'h33; // '3'
      4'd8:    c = 8'h4D; // 'M'
      4'd9:    c = 8'h4E; // 'N'
      4'd10:   c = 8'h42; // 'B'
      4'd11:   c = 8'h56; // 'V'
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- src/bmtf_front.sv -----
module bmtf_front
  import bmtf_pkg::*;
#(
  parameter logic [BTN_W-1:0] USED_MASK = 12'hFFF
) (
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [BTN_W-1:0] button_mask,
  input  q_status_t        q_stat,
  output logic             q_push,
  output logic [BTN_W-1:0] q_wdata
);

  logic             accept;
  logic [BTN_W-1:0] masked;

  // drop unused buttons, empty masks make no frame and are not queued
  assign masked   = button_mask & USED_MASK;
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign q_push   = accept && (masked != '0);
  assign q_wdata  = masked;

endmodule

// ----- src/bmtf_queue.sv -----
module bmtf_queue
  import bmtf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [BTN_W-1:0] wdata,
  input  logic             pop,
  output logic [BTN_W-1:0] rdata,
  output q_status_t        stat
);

  logic [BTN_W-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assign rdata      = mem[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

endmodule

// ----- src/bmtf_back.sv -----
module bmtf_back
  import bmtf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  q_status_t         q_stat,
  input  logic [BTN_W-1:0]  q_rdata,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              frame_end
);

  seq_state_t        state, state_next;
  logic [BTN_W-1:0]  rest, rest_next;
  logic              out_valid_next;
  logic [BYTE_W-1:0] out_byte_next;
  logic              frame_end_next;
  logic              out_load;
  logic [BTN_W-1:0]  low_bit;
  logic [BTN_W-1:0]  rest_clr;
  logic [IDX_W-1:0]  low_idx;

  // lowest pressed button still to send
  always_comb begin
    low_idx = '0;
    for (int i = BTN_W - 1; i >= 0; i--) begin
      if (rest[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end

  assign low_bit  = rest & (~rest + 12'd1);
  assign rest_clr = rest & ~low_bit;
  assign out_load = !out_valid || !out_stall;

  // state register and output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SEQ_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rest      <= rest_next;
    out_byte  <= out_byte_next;
    frame_end <= frame_end_next;
  end

  // one frame word per free output slot
  always_comb begin
    state_next     = state;
    rest_next      = rest;
    q_pop          = 1'b0;
    out_valid_next = out_load ? 1'b0 : out_valid;
    out_byte_next  = out_byte;
    frame_end_next = frame_end;
    if (out_load) begin
      case (state)
        SEQ_IDLE: begin
          if (!q_stat.empty) begin
            q_pop          = 1'b1;
            rest_next      = q_rdata;
            out_valid_next = 1'b1;
            out_byte_next  = cfg.start_code;
            frame_end_next = 1'b0;
            state_next     = SEQ_LETTER;
          end
        end
        SEQ_LETTER: begin
          rest_next      = rest_clr;
          out_valid_next = 1'b1;
          out_byte_next  = letter_of(low_idx);
          frame_end_next = 1'b0;
          state_next     = (rest_clr != '0) ? SEQ_SEP : SEQ_END;
        end
        SEQ_SEP: begin
          out_valid_next = 1'b1;
          out_byte_next  = cfg.separator_code;
          frame_end_next = 1'b0;
          state_next     = SEQ_LETTER;
        end
        SEQ_END: begin
          out_valid_next = 1'b1;
          out_byte_next  = cfg.end_code;
          frame_end_next = 1'b1;
          state_next     = SEQ_IDLE;
        end
        default: begin
          state_next = SEQ_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/button_mask_to_text_frame_unit.sv -----
// Turns each button mask into a text frame: start code, one letter per pressed
// button (lowest bit first, with the separator code between letters), end code,
// the end code flagged by frame_end. A mask with no used button set is accepted
// and gives no frame. A mask with p buttons set gives 2p+1 words, 3 to 25,
// which the output sequencer sends one word per cycle while out_stall is low;
// that sequencer sets the sustained rate. Up to two masks wait in a queue ahead
// of it, and input is stalled only while it is full.
module button_mask_to_text_frame_unit
  import bmtf_pkg::*;
#(
  parameter int BUTTON_COUNT = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BTN_W-1:0]     button_mask,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 frame_end
);

  localparam int UsedRaw = (BUTTON_COUNT > BTN_W) ? BTN_W : BUTTON_COUNT;
  localparam int Used    = (UsedRaw < 1) ? 1 : UsedRaw;
  localparam logic [BTN_W-1:0] UsedMask = BTN_W'((33'd1 << Used) - 33'd1);

  cfg_t             cfg;
  q_status_t        q_stat;
  logic             q_push;
  logic             q_pop;
  logic [BTN_W-1:0] q_wdata;
  logic [BTN_W-1:0] q_rdata;

  // frame code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_code     <= START_RST;
      cfg.end_code       <= END_RST;
      cfg.separator_code <= SEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START: cfg.start_code     <= cfg_data;
        CFG_END:   cfg.end_code       <= cfg_data;
        CFG_SEP:   cfg.separator_code <= cfg_data;
        default: ;
      endcase
    end
  end

  bmtf_front #(
    .USED_MASK (UsedMask)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .button_mask (button_mask),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  bmtf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  bmtf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .frame_end (frame_end)
  );

`ifndef SYNTHESIS
  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("mask queue overflow");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("mask queue underflow");

  // a mask with a used button set is queued for the sequencer
  a_mask_queued: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && ((button_mask & UsedMask) != '0)) |=> !q_stat.empty)
    else $error("accepted mask lost");
`endif

endmodule
